/* rtl/core/wrrpq_pkg.sv */
// ----------------------------------------------------------------------------
// wrrpq_pkg
// Types and constants shared by the weighted round robin queue block.
// ----------------------------------------------------------------------------
package wrrpq_pkg;

  localparam int unsigned NumQueues  = 4;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdBits     = 16;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned NumWeights = 4;
  localparam int unsigned QBits      = 3;
  localparam int unsigned CntBits    = $clog2(QueueDepth + 1);
  localparam int unsigned RankBits   = 18;
  localparam int unsigned NRBits     = $clog2(MaxResults + 1);

  localparam logic [6:0] AgeThresholdReset = 7'd60;

  typedef enum logic [2:0] {
    KIND_SERVED    = 3'd0,
    KIND_ENQUEUED  = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_BAD_QUEUE = 3'd3,
    KIND_EMPTY     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    REG_AGE = 3'd0,
    REG_W0  = 3'd1,
    REG_W1  = 3'd2,
    REG_W2  = 3'd3,
    REG_W3  = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SERVE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [IdBits-1:0]   id;
    logic [RankBits-1:0] rank;
  } person_t;

  // Row command: insert shifts worse entries right, pop shifts all left.
  typedef struct packed {
    logic    ins;
    logic    pop;
    person_t person;
  } row_cmd_t;

endpackage

/* rtl/core/wrrpq_cell.sv */
// ----------------------------------------------------------------------------
// wrrpq_cell
// One slot of a sorted queue row; trades its entry with its neighbors.
// ----------------------------------------------------------------------------
module wrrpq_cell (
  input  logic                clk_i,
  input  logic                cmd_ins_i,
  input  logic                cmd_pop_i,
  input  wrrpq_pkg::person_t  new_i,
  input  logic                valid_i,
  input  logic                left_valid_i,
  input  logic                left_moves_i,
  input  wrrpq_pkg::person_t  left_i,
  input  wrrpq_pkg::person_t  right_i,
  output logic                moves_o,
  output wrrpq_pkg::person_t  entry_o
);

  wrrpq_pkg::person_t entry_q, entry_d;

  // Entry is displaced when the new person ranks strictly better.
  assign moves_o = valid_i && (new_i.rank < entry_q.rank);

  always_comb begin
    entry_d = entry_q;
    if (cmd_pop_i) begin
      entry_d = right_i;
    end else if (cmd_ins_i) begin
      if (left_moves_i) begin
        entry_d = left_i;
      end else if (moves_o || (!valid_i && left_valid_i)) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/core/wrrpq_row.sv */
// ----------------------------------------------------------------------------
// wrrpq_row
// Chain of cells holding one priority queue, best entry at the head.
// ----------------------------------------------------------------------------
module wrrpq_row (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wrrpq_pkg::row_cmd_t                 cmd_i,
  output wrrpq_pkg::person_t                  head_o,
  output logic [wrrpq_pkg::CntBits-1:0]       count_o
);

  localparam int unsigned D = wrrpq_pkg::QueueDepth;

  logic [D-1:0]       valid;
  logic [D-1:0]       moves;
  wrrpq_pkg::person_t entry [D];
  logic [wrrpq_pkg::CntBits-1:0] count_q;

  always_comb begin
    for (int i = 0; i < D; i++) begin
      valid[i] = (wrrpq_pkg::CntBits'(i) < count_q);
    end
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    wrrpq_pkg::person_t left_e, right_e;
    logic left_v, left_m;
    if (i == 0) begin : g_first
      assign left_e = cmd_i.person;
      assign left_v = 1'b1;
      assign left_m = 1'b0;
    end else begin : g_mid
      assign left_e = entry[i-1];
      assign left_v = valid[i-1];
      assign left_m = moves[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_inner
      assign right_e = entry[i+1];
    end
    wrrpq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_ins_i    (cmd_i.ins),
      .cmd_pop_i    (cmd_i.pop),
      .new_i        (cmd_i.person),
      .valid_i      (valid[i]),
      .left_valid_i (left_v),
      .left_moves_i (left_m),
      .left_i       (left_e),
      .right_i      (right_e),
      .moves_o      (moves[i]),
      .entry_o      (entry[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.pop) begin
      count_q <= count_q - 1'b1;
    end else if (cmd_i.ins) begin
      count_q <= count_q + 1'b1;
    end
  end

  assign head_o  = entry[0];
  assign count_o = count_q;

endmodule

/* rtl/core/weighted_round_robin_priority_queues_top.sv */
// ----------------------------------------------------------------------------
// weighted_round_robin_priority_queues_top
// Priority queues in sorted cell rows, drained by weighted round robin.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start_i with the request fields while busy_o is low. In an enqueue
//   the request is checked and, if taken, inserted into the cell row of its
//   queue, and the single result (last_o = 1) strobes with result_valid_o in
//   the next cycle. A serve round gives N results, one per pop cycle, each
//   popping the head cell of a row, and steps past each queue that is empty
//   or has used its weight. A round with all queues empty steps through
//   every queue and gives one nothing-waiting result.
//   The popping sequencer sets the rate: one result per pop cycle.
//   Results are shown for one cycle; the receiver cannot stall.
//   Configuration writes (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   are always taken; write only while idle.
//   Reset empties every queue and loads threshold 60 and weights of 1.
// ----------------------------------------------------------------------------
module weighted_round_robin_priority_queues_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [2:0]  queue_index_i,
  input  logic [15:0] person_id_i,
  input  logic [6:0]  age_i,
  input  logic [4:0]  arrival_hour_i,
  input  logic [5:0]  arrival_minute_i,
  input  logic [5:0]  arrival_second_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [2:0]  queue_index_out_o,
  output logic [15:0] person_id_out_o,
  output logic        senior_out_o,
  output logic        last_o
);

  localparam int unsigned NQ = wrrpq_pkg::NumQueues;
  localparam int unsigned QB = wrrpq_pkg::QBits;

  logic [6:0] age_thr_q;
  logic [4:0] weight_q [wrrpq_pkg::NumWeights];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_thr_q <= wrrpq_pkg::AgeThresholdReset;
      for (int i = 0; i < wrrpq_pkg::NumWeights; i++) weight_q[i] <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wrrpq_pkg::REG_AGE: age_thr_q   <= cfg_data_i;
        wrrpq_pkg::REG_W0:  weight_q[0] <= cfg_data_i[4:0];
        wrrpq_pkg::REG_W1:  weight_q[1] <= cfg_data_i[4:0];
        wrrpq_pkg::REG_W2:  weight_q[2] <= cfg_data_i[4:0];
        wrrpq_pkg::REG_W3:  weight_q[3] <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  wrrpq_pkg::row_cmd_t                cmd   [NQ];
  wrrpq_pkg::person_t                 head  [NQ];
  logic [wrrpq_pkg::CntBits-1:0]      count [NQ];

  for (genvar q = 0; q < NQ; q++) begin : g_row
    wrrpq_row u_row (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd[q]),
      .head_o  (head[q]),
      .count_o (count[q])
    );
  end

  wrrpq_pkg::state_e           state_q, state_d;
  logic [QB-1:0]               q_q, q_d;
  logic [4:0]                  served_q, served_d;
  logic [wrrpq_pkg::NRBits-1:0] n_q, n_d;
  logic [QB-1:0]               req_q_q;
  wrrpq_pkg::person_t          req_p_q;

  logic                        rv_d, rv_q, last_d, last_q, sen_d, sen_q;
  logic [2:0]                  kind_d, kind_q;
  logic [QB-1:0]               qo_d, qo_q;
  logic [15:0]                 id_d, id_q;

  logic [4:0]                  wcur;
  logic                        cur_ok;
  logic [wrrpq_pkg::CntBits-1:0] cur_cnt;
  logic                        more;
  logic                        senior_new;

  assign senior_new = (age_i >= age_thr_q);

  always_comb begin
    wcur = 5'd1;
    if (q_q < QB'(wrrpq_pkg::NumWeights)) begin
      wcur = weight_q[q_q[1:0]];
    end
    if (wcur == 5'd0) wcur = 5'd1;
    cur_ok  = (q_q < QB'(NQ));
    cur_cnt = cur_ok ? count[q_q[1:0]] : '0;
  end

  always_comb begin
    state_d  = state_q;
    q_d      = q_q;
    served_d = served_q;
    n_d      = n_q;
    rv_d     = 1'b0;
    kind_d   = wrrpq_pkg::KIND_SERVED;
    qo_d     = '0;
    id_d     = '0;
    sen_d    = 1'b0;
    last_d   = 1'b0;
    more     = 1'b0;
    for (int q = 0; q < NQ; q++) begin
      cmd[q].ins    = 1'b0;
      cmd[q].pop    = 1'b0;
      cmd[q].person = req_p_q;
    end
    unique case (state_q)
      wrrpq_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d  = operation_i ? wrrpq_pkg::ST_SERVE : wrrpq_pkg::ST_INSERT;
          q_d      = '0;
          served_d = '0;
          n_d      = '0;
        end
      end
      wrrpq_pkg::ST_INSERT: begin
        rv_d   = 1'b1;
        last_d = 1'b1;
        qo_d   = req_q_q;
        state_d = wrrpq_pkg::ST_IDLE;
        if (req_q_q >= QB'(NQ)) begin
          kind_d = wrrpq_pkg::KIND_BAD_QUEUE;
        end else if (count[req_q_q[1:0]] >= wrrpq_pkg::CntBits'(wrrpq_pkg::QueueDepth))
        begin
          kind_d = wrrpq_pkg::KIND_FULL;
        end else begin
          kind_d = wrrpq_pkg::KIND_ENQUEUED;
          cmd[req_q_q[1:0]].ins = 1'b1;
        end
      end
      wrrpq_pkg::ST_SERVE: begin
        if (!cur_ok) begin
          state_d = wrrpq_pkg::ST_DONE;
        end else if (cur_cnt != '0 && served_q < wcur
                     && n_q < wrrpq_pkg::NRBits'(wrrpq_pkg::MaxResults)) begin
          cmd[q_q[1:0]].pop = 1'b1;
          rv_d   = 1'b1;
          kind_d = wrrpq_pkg::KIND_SERVED;
          qo_d   = q_q;
          id_d   = head[q_q[1:0]].id;
          sen_d  = ~head[q_q[1:0]].rank[wrrpq_pkg::RankBits-1];
          n_d    = n_q + 1'b1;
          served_d = served_q + 1'b1;
          // mark last when no further pop can follow in this round
          more = (n_d < wrrpq_pkg::NRBits'(wrrpq_pkg::MaxResults))
                 && ((cur_cnt > 1 && served_d < wcur));
          for (int q = 0; q < NQ; q++) begin
            if (QB'(q) > q_q && count[q] != '0) more = more
              || (n_d < wrrpq_pkg::NRBits'(wrrpq_pkg::MaxResults));
          end
          last_d = !more;
          if (!more) state_d = wrrpq_pkg::ST_IDLE;
        end else begin
          q_d      = q_q + 1'b1;
          served_d = '0;
        end
      end
      wrrpq_pkg::ST_DONE: begin
        state_d = wrrpq_pkg::ST_IDLE;
        rv_d    = 1'b1;
        kind_d  = wrrpq_pkg::KIND_EMPTY;
        last_d  = 1'b1;
      end
      default: state_d = wrrpq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wrrpq_pkg::ST_IDLE;
      q_q      <= '0;
      served_q <= '0;
      n_q      <= '0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      q_q      <= q_d;
      served_q <= served_d;
      n_q      <= n_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    qo_q   <= qo_d;
    id_q   <= id_d;
    sen_q  <= sen_d;
    last_q <= last_d;
    if (state_q == wrrpq_pkg::ST_IDLE && start_i) begin
      req_q_q <= queue_index_i;
      req_p_q.id   <= person_id_i[wrrpq_pkg::IdBits-1:0];
      req_p_q.rank <= {~senior_new, arrival_hour_i, arrival_minute_i, arrival_second_i};
    end
  end

  assign busy_o            = (state_q != wrrpq_pkg::ST_IDLE);
  assign result_valid_o    = rv_q;
  assign kind_o            = kind_q;
  assign queue_index_out_o = qo_q;
  assign person_id_out_o   = id_q;
  assign senior_out_o      = sen_q;
  assign last_o            = last_q;

endmodule

/* test/weighted_round_robin_priority_queues_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_round_robin_priority_queues_top_test
// Drives directed and random enqueue and serve requests, predicts every result
// from a software copy of the sorted queues, and checks them in order.
// ----------------------------------------------------------------------------
module weighted_round_robin_priority_queues_top_test;

  typedef struct {
    logic       op;
    logic [2:0] q;
    logic [15:0] id;
    logic [6:0] age;
    logic [4:0] hh;
    logic [5:0] mm;
    logic [5:0] ss;
  } request_t;

  typedef struct {
    wrrpq_pkg::kind_e kind;
    logic [2:0]  q;
    logic [15:0] id;
    logic        senior;
    logic        last;
  } outcome_t;

  typedef struct {
    logic [15:0] id;
    logic [17:0] rank;
  } waiting_t;

  typedef struct {
    request_t req;
    logic     has_exp;
    outcome_t exp;
  } row_t;

  localparam int unsigned WatchdogLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic operation_i = 1'b0;
  logic [2:0] queue_index_i = '0;
  logic [15:0] person_id_i = '0;
  logic [6:0] age_i = '0;
  logic [4:0] arrival_hour_i = '0;
  logic [5:0] arrival_minute_i = '0;
  logic [5:0] arrival_second_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, result_valid_o, senior_out_o, last_o;
  logic [2:0] kind_o, queue_index_out_o;
  logic [15:0] person_id_out_o;

  logic [6:0] model_age;
  logic [4:0] model_weight [wrrpq_pkg::NumWeights];
  waiting_t model_rows [wrrpq_pkg::NumQueues][$];
  outcome_t pending_results [$];
  int errors = 0;
  int idle_cycles = 0;
  row_t directed [$];

  weighted_round_robin_priority_queues_top dut (.*);

  always #1 clk_i = ~clk_i;

  // Work out the results of one accepted request and update the model.
  function automatic void predict_request(request_t r);
    outcome_t o;
    waiting_t p;
    int pos, n, w;
    logic senior;
    o = '{wrrpq_pkg::KIND_ENQUEUED, r.q, 16'd0, 1'b0, 1'b1};
    if (!r.op) begin
      if (r.q >= wrrpq_pkg::NumQueues) begin
        o.kind = wrrpq_pkg::KIND_BAD_QUEUE;
      end else if (model_rows[r.q].size() >= wrrpq_pkg::QueueDepth) begin
        o.kind = wrrpq_pkg::KIND_FULL;
      end else begin
        senior = r.age >= model_age;
        p.id = r.id;
        p.rank = {~senior, r.hh, r.mm, r.ss};
        pos = 0;
        while (pos < model_rows[r.q].size() && model_rows[r.q][pos].rank <= p.rank) pos++;
        model_rows[r.q].insert(pos, p);
      end
      pending_results.push_back(o);
    end else begin
      n = 0;
      for (int q = 0; q < wrrpq_pkg::NumQueues; q++) begin
        w = (q < wrrpq_pkg::NumWeights) ? model_weight[q] : 1;
        if (w == 0) w = 1;
        for (int j = 0; j < w && model_rows[q].size() > 0 && n < wrrpq_pkg::MaxResults;
             j++) begin
          p = model_rows[q].pop_front();
          pending_results.push_back('{wrrpq_pkg::KIND_SERVED, q[2:0], p.id, ~p.rank[17],
                                      1'b0});
          n++;
        end
      end
      if (n == 0) pending_results.push_back('{wrrpq_pkg::KIND_EMPTY, 3'd0, 16'd0, 1'b0,
                                              1'b1});
      else pending_results[$].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", kind_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, kind_o); errors++;
        end
        if (queue_index_out_o !== e.q) begin
          $error("queue_index_out expected %0d actual %0d", e.q, queue_index_out_o);
          errors++;
        end
        if (person_id_out_o !== e.id) begin
          $error("person_id_out expected %0h actual %0h", e.id, person_id_out_o);
          errors++;
        end
        if (senior_out_o !== e.senior) begin
          $error("senior_out expected %0b actual %0b", e.senior, senior_out_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $error("last expected %0b actual %0b", e.last, last_o); errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted request, no config write and no result.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || cfg_valid_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(wrrpq_pkg::reg_e idx, logic [6:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == wrrpq_pkg::REG_AGE) model_age = val;
    else model_weight[idx - 1] = val[4:0];
  endtask

  // Hold until every result is in, then let the block settle.
  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Issue one request at the edge; stays high while the block is busy.
  task automatic send_request(request_t r);
    start_i <= 1'b1;
    operation_i <= r.op;
    queue_index_i <= r.q;
    person_id_i <= r.id;
    age_i <= r.age;
    arrival_hour_i <= r.hh;
    arrival_minute_i <= r.mm;
    arrival_second_i <= r.ss;
    do @(posedge clk_i); while (busy_o);
    predict_request(r);
  endtask

  function automatic request_t rand_request(int serve_pct, int qmax);
    request_t r;
    r.op = ($urandom_range(99) < serve_pct);
    r.q = 3'((qmax > 3 && $urandom_range(9) == 0) ? $urandom_range(7)
                                                   : $urandom_range(qmax));
    r.id = 16'($urandom);
    r.age = 7'($urandom);
    r.hh = 5'(($urandom_range(15) == 0) ? $urandom : $urandom_range(23));
    r.mm = 6'(($urandom_range(15) == 0) ? $urandom : $urandom_range(59));
    r.ss = 6'(($urandom_range(15) == 0) ? $urandom : $urandom_range(59));
    // Narrow the time range now and then so equal keys occur.
    if ($urandom_range(3) == 0) begin
      r.hh = 5'd7; r.mm = 6'd30; r.ss = 6'($urandom_range(1));
    end
    return r;
  endfunction

  task automatic send_burst(int count, int serve_pct, int qmax);
    request_t r;
    int left;
    int gap;
    left = count;
    while (left > 0) begin
      for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
        r = rand_request(serve_pct, qmax);
        send_request(r);
        left--;
      end
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;
  endtask

  initial begin
    request_t r;
    model_age = wrrpq_pkg::AgeThresholdReset;
    foreach (model_weight[i]) model_weight[i] = 5'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: enqueues and serves, typed expectations after reset and for error codes.
    directed.push_back('{'{1'b1, 3'd0, 16'd0, 7'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
                         '{wrrpq_pkg::KIND_EMPTY, 3'd0, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b0, 3'd7, 16'hFFFF, 7'd127, 5'd31, 6'd63, 6'd63}, 1'b1,
                         '{wrrpq_pkg::KIND_BAD_QUEUE, 3'd7, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b0, 3'd4, 16'h1234, 7'd5, 5'd1, 6'd1, 6'd1}, 1'b1,
                         '{wrrpq_pkg::KIND_BAD_QUEUE, 3'd4, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b0, 3'd0, 16'hFFFF, 7'd127, 5'd23, 6'd59, 6'd59}, 1'b0,
                         '{wrrpq_pkg::KIND_ENQUEUED, 3'd0, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b0, 3'd0, 16'h0000, 7'd0, 5'd0, 6'd0, 6'd0}, 1'b0,
                         '{wrrpq_pkg::KIND_ENQUEUED, 3'd0, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b0, 3'd0, 16'h0001, 7'd60, 5'd23, 6'd59, 6'd59}, 1'b0,
                         '{wrrpq_pkg::KIND_ENQUEUED, 3'd0, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b0, 3'd3, 16'h0002, 7'd59, 5'd31, 6'd63, 6'd63}, 1'b0,
                         '{wrrpq_pkg::KIND_ENQUEUED, 3'd0, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b0, 3'd3, 16'h0003, 7'd59, 5'd0, 6'd0, 6'd0}, 1'b0,
                         '{wrrpq_pkg::KIND_ENQUEUED, 3'd0, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b1, 3'd5, 16'hAAAA, 7'd99, 5'd9, 6'd9, 6'd9}, 1'b0,
                         '{wrrpq_pkg::KIND_EMPTY, 3'd0, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b1, 3'd0, 16'd0, 7'd0, 5'd0, 6'd0, 6'd0}, 1'b0,
                         '{wrrpq_pkg::KIND_EMPTY, 3'd0, 16'd0, 1'b0, 1'b1}});
    directed.push_back('{'{1'b1, 3'd0, 16'd0, 7'd0, 5'd0, 6'd0, 6'd0}, 1'b0,
                         '{wrrpq_pkg::KIND_EMPTY, 3'd0, 16'd0, 1'b0, 1'b1}});
    foreach (directed[i]) begin
      send_request(directed[i].req);
      if (directed[i].has_exp) begin
        // Replace the predicted entry with the typed one.
        void'(pending_results.pop_back());
        pending_results.push_back(directed[i].exp);
      end
    end
    start_i <= 1'b0;
    drain();

    // Fill queue 1 past its depth to reach the full rejection.
    for (int i = 0; i < wrrpq_pkg::QueueDepth + 2; i++) begin
      r = '{1'b0, 3'd1, i[15:0], 7'd20, 5'd3, 6'd3, i[5:0] & 6'd3};
      send_request(r);
    end
    start_i <= 1'b0;
    drain();

    // Phases over several settings, extremes included.
    write_reg(wrrpq_pkg::REG_AGE, 7'd0);
    write_reg(wrrpq_pkg::REG_W0, 7'd16);
    write_reg(wrrpq_pkg::REG_W1, 7'd16);
    write_reg(wrrpq_pkg::REG_W2, 7'd16);
    write_reg(wrrpq_pkg::REG_W3, 7'd16);
    send_burst(90, 8, 3);
    drain();
    write_reg(wrrpq_pkg::REG_AGE, 7'd127);
    write_reg(wrrpq_pkg::REG_W0, 7'd0);
    write_reg(wrrpq_pkg::REG_W1, 7'd31);
    write_reg(wrrpq_pkg::REG_W2, 7'd1);
    write_reg(wrrpq_pkg::REG_W3, 7'd2);
    send_burst(90, 25, 7);
    drain();
    write_reg(wrrpq_pkg::REG_AGE, 7'($urandom_range(30, 90)));
    write_reg(wrrpq_pkg::REG_W0, 7'($urandom_range(1, 4)));
    write_reg(wrrpq_pkg::REG_W1, 7'($urandom_range(1, 4)));
    write_reg(wrrpq_pkg::REG_W2, 7'($urandom_range(1, 4)));
    write_reg(wrrpq_pkg::REG_W3, 7'($urandom_range(1, 4)));
    send_burst(90, 20, 7);
    drain();
    write_reg(wrrpq_pkg::REG_AGE, 7'd60);
    write_reg(wrrpq_pkg::REG_W0, 7'd1);
    write_reg(wrrpq_pkg::REG_W1, 7'd1);
    write_reg(wrrpq_pkg::REG_W2, 7'd1);
    write_reg(wrrpq_pkg::REG_W3, 7'd1);
    send_burst(80, 30, 7);
    drain();
    repeat (20) @(posedge clk_i);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
